// File: sv/iff_chunk_header_parser_macros.svh
// Assertion macros for the IFF chunk header parser.
// Included by the top level; expects signals named clk and rst_n in scope.
`ifndef IFF_CHUNK_HEADER_PARSER_MACROS_SVH
`define IFF_CHUNK_HEADER_PARSER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define IFFCHP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define IFFCHP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/iffchp_pkg.sv
// Package for the IFF chunk header parser: constants, event type, state type
// and character class helpers. No dependencies.
`default_nettype none

package iffchp_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int WINDOW_BYTES    = 12;

    localparam logic [31:0] TAG_FORM = 32'h464F_524D;
    localparam logic [31:0] TAG_NULL = 32'h4E55_4C4C;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [1:0] KIND_FOLDER   = 2'd0;
    localparam logic [1:0] KIND_DATA     = 2'd1;
    localparam logic [1:0] KIND_BAD_NAME = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    localparam logic [3:0] NAME_LEN_SHORT = 4'd4;
    localparam logic [3:0] NAME_LEN_LONG  = 4'd8;

    typedef enum logic {
        ST_RUN,
        ST_POP
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  depth;
        logic [3:0]  name_len;
        logic [63:0] name;
        logic [31:0] size;
        logic [31:0] poff;
    } ev_t;

    function automatic logic name_char(input logic [7:0] c);
        return (c inside {[CHAR_A:CHAR_Z], [CHAR_0:CHAR_9], CHAR_SPACE});
    endfunction

    function automatic logic name4(input logic [31:0] w);
        return name_char(w[31:24]) && name_char(w[23:16]) &&
               name_char(w[15:8]) && name_char(w[7:0]);
    endfunction

endpackage

`default_nettype wire

// File: sv/iffchp_ifs.sv
// Valid/ready channel interfaces of the IFF chunk header parser.
// The byte channel feeds the parser; the event channel carries its results.
`default_nettype none

interface iffchp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface iffchp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [4:0]  nest_depth;
    logic [3:0]  name_length;
    logic [63:0] chunk_name;
    logic [31:0] chunk_size;
    logic [31:0] payload_offset;

    modport source (output valid, output event_kind, output nest_depth,
                    output name_length, output chunk_name, output chunk_size,
                    output payload_offset, input ready);
    modport sink (input valid, input event_kind, input nest_depth,
                  input name_length, input chunk_name, input chunk_size,
                  input payload_offset, output ready);
endinterface

`default_nettype wire

// File: sv/iffchp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module iffchp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/iff_chunk_header_parser.sv
// IFF chunk header parser, top level. Depends on iffchp_pkg, the channel
// interfaces in iffchp_ifs.sv, iffchp_ram and the assertion macro header.
//
//   channel     direction  payload
//   bytes_in    sink       data_byte, last_byte
//   events_out  source     event_kind, nest_depth, name_length, chunk_name,
//                          chunk_size, payload_offset
//
// One byte is taken per cycle while no pop runs and the skid entry is empty.
// The top of the end offset stack is cached in a register, so a chunk boundary
// costs nothing unless the cached top matches and deeper entries remain; each
// further entry is then read from the stack RAM and compared; bytes stall.
// Reset is asynchronous and active low; the stack RAM needs no clearing pass.
// A two-entry output stage lets bytes flow while one event waits downstream.
`default_nettype none
`include "iff_chunk_header_parser_macros.svh"

module iff_chunk_header_parser
    import iffchp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input wire logic     clk,
    input wire logic     rst_n,
    iffchp_in_if.sink    bytes_in,
    iffchp_out_if.source events_out
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_TWO  = CW'(2);
    localparam logic [OFFSET_BITS-1:0] OFF_ONE   = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_THREE = OFFSET_BITS'(3);

    state_t state_reg, state_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [3:0]             fill_reg, fill_next;
    logic [31:0]            skip_reg, skip_next;
    logic                   err_reg, err_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   pend_last_reg, pend_last_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   skid_valid_reg, skid_valid_next;

    logic [7:0]             win_reg [WINDOW_BYTES];
    logic [OFFSET_BITS-1:0] top_reg;
    logic [OFFSET_BITS-1:0] pos_reg;
    ev_t                    pend_reg;
    ev_t                    out_reg, out_next;
    ev_t                    skid_reg, skid_next;

    logic [7:0]             cur [WINDOW_BYTES];
    logic [31:0]            hdr0, hdr1, hdr2;
    logic                   in_fire, out_fire, active;
    logic [3:0]             fill_inc, fill_after;
    logic                   is_long, null_case, bad, finish, len8, folder, overflow;
    logic                   push, trunc, ev_valid;
    logic [31:0]            size_v;
    logic [63:0]            name_v;
    logic [OFFSET_BITS-1:0] poff_v, pop_pos;
    logic                   pop_req, pop_hit, go_pop;
    logic [CW-1:0]          cnt_after, cnt_m2, cnt_pop;
    logic                   pop_match, pop_more;
    ev_t                    ev_core, emit_ev;
    logic                   emit_valid;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [OFFSET_BITS-1:0] ram_wdata, ram_rdata;

    iffchp_ram #(
        .WIDTH(OFFSET_BITS),
        .DEPTH(STACK_DEPTH)
    ) u_stack_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Handshake and output drive.
    always_comb
    begin
        bytes_in.ready            = (state_reg == ST_RUN) && !skid_valid_reg;
        events_out.valid          = out_valid_reg;
        events_out.event_kind     = out_reg.kind;
        events_out.nest_depth     = out_reg.depth;
        events_out.name_length    = out_reg.name_len;
        events_out.chunk_name     = out_reg.name;
        events_out.chunk_size     = out_reg.size;
        events_out.payload_offset = out_reg.poff;
    end

    assign in_fire  = bytes_in.valid && bytes_in.ready;
    assign out_fire = out_valid_reg && events_out.ready;

    // Header decode of the incoming byte.
    always_comb
    begin
        for (int i = 0; i < WINDOW_BYTES; i++)
        begin
            cur[i] = (fill_reg == 4'(i)) ? bytes_in.data_byte : win_reg[i];
        end
        hdr0 = {cur[0], cur[1], cur[2], cur[3]};
        hdr1 = {cur[4], cur[5], cur[6], cur[7]};
        hdr2 = {cur[8], cur[9], cur[10], cur[11]};

        active    = in_fire && !err_reg && (skip_reg == 32'd0);
        fill_inc  = fill_reg + 4'd1;
        is_long   = name4(hdr1);
        null_case = active && (fill_inc == 4'd8) && !is_long && (hdr0 == TAG_NULL);
        bad       = (active && (fill_inc == 4'd4) && !name4(hdr0)) || null_case;
        len8      = (fill_inc == 4'(WINDOW_BYTES));
        finish    = active && (len8 || ((fill_inc == 4'd8) && !is_long && !null_case));

        size_v   = len8 ? hdr2 : hdr1;
        name_v   = len8 ? {hdr0, hdr1} : {hdr0, 32'h0};
        poff_v   = off_reg + OFF_ONE;
        folder   = (size_v >= 32'd4) && ((hdr0 == TAG_FORM) || (len8 && (hdr1 == TAG_FORM)));
        overflow = (cnt_reg >= CNT_FULL);
        push     = finish && folder && !overflow;

        if (!active)
        begin
            fill_after = fill_reg;
        end
        else if (bad || finish)
        begin
            fill_after = 4'd0;
        end
        else
        begin
            fill_after = fill_inc;
        end

        trunc    = in_fire && bytes_in.last_byte && !bad && !finish && !err_reg &&
                   (fill_after != 4'd0);
        ev_valid = bad || finish || trunc;

        ev_core = '0;
        if (finish)
        begin
            ev_core.kind     = folder ? (overflow ? KIND_OVERFLOW : KIND_FOLDER) : KIND_DATA;
            ev_core.name_len = len8 ? NAME_LEN_LONG : NAME_LEN_SHORT;
            ev_core.name     = name_v;
            ev_core.size     = size_v;
            ev_core.poff     = 32'(poff_v);
        end
        else if (bad)
        begin
            ev_core.kind = KIND_BAD_NAME;
        end
        else
        begin
            ev_core.kind = KIND_OVERFLOW;
        end

        pop_req   = active && ((fill_reg == 4'd0) || null_case);
        pop_pos   = (fill_reg == 4'd0) ? off_reg : (off_reg - OFF_THREE);
        pop_hit   = pop_req && (cnt_reg != '0) && (top_reg == pop_pos);
        cnt_after = cnt_reg - (pop_hit ? CNT_ONE : '0);
        go_pop    = pop_hit && (cnt_after != '0);

        cnt_m2    = cnt_reg - CNT_TWO;
        cnt_pop   = cnt_reg - CNT_ONE;
        pop_match = (ram_rdata == pos_reg);
        pop_more  = pop_match && (cnt_pop != '0);

        ram_we    = push;
        ram_waddr = cnt_reg[AW-1:0];
        ram_wdata = poff_v + size_v[OFFSET_BITS-1:0];
        ram_raddr = cnt_m2[AW-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (go_pop)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (!pop_more)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Parser state updates and event emission.
    always_comb
    begin
        off_next        = off_reg;
        cnt_next        = cnt_reg;
        fill_next       = fill_reg;
        skip_next       = skip_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        emit_valid      = 1'b0;
        emit_ev         = ev_core;

        case (state_reg)
            ST_RUN:
            begin
                if (in_fire)
                begin
                    off_next  = poff_v;
                    fill_next = fill_after;
                    cnt_next  = cnt_after + (push ? CNT_ONE : '0);
                    if (in_fire && !err_reg && (skip_reg != 32'd0))
                    begin
                        skip_next = skip_reg - 32'd1;
                    end
                    if (finish && !folder)
                    begin
                        skip_next = size_v;
                    end
                    if (bad || (finish && folder && overflow))
                    begin
                        err_next = 1'b1;
                    end
                    if (go_pop)
                    begin
                        pend_valid_next = ev_valid;
                        pend_last_next  = bytes_in.last_byte;
                    end
                    else
                    begin
                        emit_valid    = ev_valid;
                        emit_ev.depth = 5'(cnt_after) + 5'd1;
                        if (bytes_in.last_byte)
                        begin
                            off_next  = '0;
                            cnt_next  = '0;
                            fill_next = 4'd0;
                            skip_next = 32'd0;
                            err_next  = 1'b0;
                        end
                    end
                end
            end
            ST_POP:
            begin
                if (pop_match)
                begin
                    cnt_next = cnt_pop;
                end
                if (!pop_more)
                begin
                    emit_valid    = pend_valid_reg;
                    emit_ev       = pend_reg;
                    emit_ev.depth = 5'(cnt_next) + 5'd1;
                    if (pend_last_reg)
                    begin
                        off_next  = '0;
                        cnt_next  = '0;
                        fill_next = 4'd0;
                        skip_next = 32'd0;
                        err_next  = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Two-entry output stage.
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (emit_valid)
        begin
            if (!out_valid_next)
            begin
                out_next       = emit_ev;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = emit_ev;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            off_reg        <= '0;
            cnt_reg        <= '0;
            fill_reg       <= 4'd0;
            skip_reg       <= 32'd0;
            err_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            off_reg        <= off_next;
            cnt_reg        <= cnt_next;
            fill_reg       <= fill_next;
            skip_reg       <= skip_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            win_reg[fill_reg] <= bytes_in.data_byte;
        end
        if (push)
        begin
            top_reg <= ram_wdata;
        end
        else if ((state_reg == ST_POP) && !pop_match)
        begin
            top_reg <= ram_rdata;
        end
        if ((state_reg == ST_RUN) && go_pop)
        begin
            pos_reg  <= pop_pos;
            pend_reg <= ev_core;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `IFFCHP_ASSERT_ALWAYS(a_stack_bound, cnt_reg <= CNT_FULL, "stack count beyond depth")
    `IFFCHP_ASSERT_IMPLY(a_pop_nonempty, state_reg == ST_POP, cnt_reg != '0,
                         "pop sequence on an empty stack")
    `IFFCHP_ASSERT_IMPLY(a_err_idle, err_reg, (fill_reg == 4'd0) && (skip_reg == 32'd0),
                         "header or skip in progress after an error")
    `IFFCHP_ASSERT_IMPLY(a_skid_order, skid_valid_reg, out_valid_reg,
                         "skid entry held with an empty output register")

endmodule

`default_nettype wire

// File: verif/iff_chunk_header_parser_test.sv
// Testbench for the IFF chunk header parser: directed streams, then random
// chunk trees, checked against a behavioral parser kept in this file.
// Depends on iffchp_pkg, the channel interfaces and the parser RTL.

module iff_chunk_header_parser_test
    import iffchp_pkg::*;
();

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sink_ready = 1'b0;
    int stall_left = 0;
    bit calm = 1'b0;
    int errors = 0;
    int live_bytes = 0;

    iffchp_in_if bytes_ch ();
    iffchp_out_if events_ch ();

    assign events_ch.ready = sink_ready;

    iff_chunk_header_parser dut (
        .clk(clk),
        .rst_n(rst_n),
        .bytes_in(bytes_ch),
        .events_out(events_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Parser state as seen by the checker.
    logic [31:0] pos_q;
    logic [31:0] ends_q [STACK_DEPTH_DEF];
    int open_cnt;
    int unsigned level;
    logic [7:0] hdr [WINDOW_BYTES];
    int hdr_fill;
    logic [31:0] skip_left;
    bit halted;

    ev_t pending_events [$];
    logic [7:0] stream_q [$];
    int size_marks [$];

    function automatic void clear_parser();
        pos_q = '0;
        open_cnt = 0;
        level = 1;
        hdr_fill = 0;
        skip_left = '0;
        halted = 1'b0;
    endfunction

    function automatic bit legal_char(input logic [7:0] c);
        return (c >= CHAR_A && c <= CHAR_Z) || (c >= CHAR_0 && c <= CHAR_9) ||
               c == CHAR_SPACE;
    endfunction

    function automatic logic [31:0] hdr_word(input int from);
        return {hdr[from], hdr[from + 1], hdr[from + 2], hdr[from + 3]};
    endfunction

    function automatic bit hdr_name4(input int from);
        return legal_char(hdr[from]) && legal_char(hdr[from + 1]) &&
               legal_char(hdr[from + 2]) && legal_char(hdr[from + 3]);
    endfunction

    function automatic void pop_ends(input logic [31:0] at);
        while (open_cnt > 0 && ends_q[open_cnt - 1] == at)
        begin
            open_cnt--;
            if (level > 1)
                level--;
        end
    endfunction

    function automatic ev_t make_event(input logic [1:0] kind, input logic [3:0] len,
                                       input logic [63:0] name, input logic [31:0] size,
                                       input logic [31:0] poff);
        ev_t ev;
        ev.kind = kind;
        ev.depth = 5'(level);
        ev.name_len = len;
        ev.name = name;
        ev.size = size;
        ev.poff = poff;
        return ev;
    endfunction

    function automatic ev_t name_error();
        halted = 1'b1;
        hdr_fill = 0;
        return make_event(KIND_BAD_NAME, '0, '0, '0, '0);
    endfunction

    function automatic ev_t close_header(input int len, input logic [31:0] here);
        logic [31:0] size;
        logic [63:0] name;
        logic [31:0] poff;
        bit folder;
        ev_t ev;
        size = hdr_word(len);
        name = {hdr_word(0), (len == 8) ? hdr_word(4) : 32'h0};
        poff = here + 32'd1;
        folder = (size >= 32'd4) &&
                 (hdr_word(0) == TAG_FORM || (len == 8 && hdr_word(4) == TAG_FORM));
        hdr_fill = 0;
        if (!folder)
        begin
            skip_left = size;
            return make_event(KIND_DATA, 4'(len), name, size, poff);
        end
        if (open_cnt >= STACK_DEPTH_DEF)
        begin
            halted = 1'b1;
            return make_event(KIND_OVERFLOW, 4'(len), name, size, poff);
        end
        ends_q[open_cnt] = poff + size;
        open_cnt++;
        ev = make_event(KIND_FOLDER, 4'(len), name, size, poff);
        level++;
        return ev;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input bit last, output ev_t ev);
        logic [31:0] here;
        bit hit;
        int i;
        hit = 1'b0;
        ev = '0;
        here = pos_q;
        pos_q = here + 32'd1;
        if (!halted)
        begin
            if (skip_left != 0)
                skip_left--;
            else
            begin
                if (hdr_fill == 0)
                    pop_ends(here);
                if (hdr_fill < WINDOW_BYTES)
                begin
                    hdr[hdr_fill] = b;
                    hdr_fill++;
                end
                if (hdr_fill == 4)
                begin
                    if (!hdr_name4(0))
                    begin
                        ev = name_error();
                        hit = 1'b1;
                    end
                end
                else if (hdr_fill == 8)
                begin
                    if (!hdr_name4(4))
                    begin
                        if (hdr_word(0) == TAG_NULL)
                        begin
                            for (i = 0; i < 4; i++)
                                hdr[i] = hdr[i + 4];
                            hdr_fill = 4;
                            pop_ends(here - 32'd3);
                            if (!hdr_name4(0))
                            begin
                                ev = name_error();
                                hit = 1'b1;
                            end
                        end
                        else
                        begin
                            ev = close_header(4, here);
                            hit = 1'b1;
                        end
                    end
                end
                else if (hdr_fill >= WINDOW_BYTES)
                begin
                    ev = close_header(8, here);
                    hit = 1'b1;
                end
            end
        end
        if (last)
        begin
            if (!hit && !halted && hdr_fill > 0)
            begin
                ev = make_event(KIND_OVERFLOW, '0, '0, '0, '0);
                hit = 1'b1;
            end
            clear_parser();
        end
        return hit;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Both handshakes are decided by the values seen at the falling edge.
    always @(negedge clk)
    begin
        ev_t want;
        if (rst_n)
        begin
            if (bytes_ch.valid && bytes_ch.ready)
            begin
                if (!halted)
                    live_bytes++;
                if (parse_byte(bytes_ch.data_byte, bytes_ch.last_byte, want))
                    pending_events.push_back(want);
            end
            if (events_ch.valid && events_ch.ready)
            begin
                if (pending_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected event, expected none, got kind %0d",
                             $time, events_ch.event_kind);
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_kind", 64'(want.kind), 64'(events_ch.event_kind));
                    check_field("nest_depth", 64'(want.depth), 64'(events_ch.nest_depth));
                    check_field("name_length", 64'(want.name_len),
                                64'(events_ch.name_length));
                    check_field("chunk_name", want.name, events_ch.chunk_name);
                    check_field("chunk_size", 64'(want.size), 64'(events_ch.chunk_size));
                    check_field("payload_offset", 64'(want.poff),
                                64'(events_ch.payload_offset));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            sink_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(1, 14) - 1;
            sink_ready <= 1'b0;
        end
        else
            sink_ready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 14);
            bytes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bytes_ch.valid <= 1'b1;
        bytes_ch.data_byte <= b;
        bytes_ch.last_byte <= last;
        @(negedge clk);
        while (!bytes_ch.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic send_stream(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_byte(stream_q[i], i == count - 1);
        stream_q.delete();
    endtask

    task automatic wait_drained();
        bytes_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
    endtask

    function automatic void add_word(input logic [31:0] w);
        int i;
        for (i = 3; i >= 0; i--)
            stream_q.push_back(w[8 * i +: 8]);
    endfunction

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            stream_q.push_back(s[i]);
    endfunction

    function automatic void add_name4();
        int i;
        int pick;
        for (i = 0; i < 4; i++)
        begin
            pick = $urandom_range(0, 5);
            if (pick < 3)
                stream_q.push_back(CHAR_A + 8'($urandom_range(0, 25)));
            else if (pick < 5)
                stream_q.push_back(CHAR_0 + 8'($urandom_range(0, 9)));
            else
                stream_q.push_back(CHAR_SPACE);
        end
    endfunction

    function automatic void add_random(input int count);
        repeat (count) stream_q.push_back(8'($urandom));
    endfunction

    // Style 0: "FORM"; style 1: "FORM" then four characters; style 2: the reverse.
    function automatic void open_folder(input int style);
        if (style == 2)
            add_name4();
        add_word(TAG_FORM);
        if (style == 1)
            add_name4();
        size_marks.push_back(stream_q.size());
        add_word('0);
    endfunction

    function automatic void close_folder();
        int at;
        int i;
        logic [31:0] span;
        at = size_marks.pop_back();
        span = 32'(stream_q.size() - at - 4);
        for (i = 0; i < 4; i++)
            stream_q[at + i] = span[31 - 8 * i -: 8];
    endfunction

    function automatic void add_data(input bit long_name, input int count);
        add_name4();
        if (long_name)
            add_name4();
        add_word(32'(count));
        add_random(count);
    endfunction

    function automatic void build_tree(input int chunks);
        int k;
        for (k = 0; k < chunks; k++)
        begin
            case ($urandom_range(0, 5))
                0, 1:
                    if (size_marks.size() < 5)
                        open_folder($urandom_range(0, 2));
                    else
                        add_data($urandom_range(0, 1), $urandom_range(0, 6));
                2:
                    if (size_marks.size() > 0)
                        close_folder();
                    else
                        add_data($urandom_range(0, 1), $urandom_range(0, 6));
                default:
                    add_data($urandom_range(0, 1),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                         : $urandom_range(0, 12));
            endcase
        end
        while (size_marks.size() > 0)
            close_folder();
    endfunction

    task automatic test_name_lengths();
        add_text("DATA");
        add_word(32'd3);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        stream_q.push_back(8'h5A);
        add_text("LONGNAME");
        add_word('0);
        add_text("AZ09 9ZA");
        add_word(32'd1);
        stream_q.push_back(8'hA5);
        send_stream(stream_q.size());
    endtask

    task automatic test_nested_folders();
        open_folder(0);
        open_folder(2);
        add_data(1'b0, 0);
        close_folder();
        close_folder();
        open_folder(1);
        add_data(1'b1, 2);
        close_folder();
        add_data(1'b0, 1);
        send_stream(stream_q.size());
    endtask

    task automatic test_null_name();
        // The dropped name sits at the end of the folder, so the pop comes first.
        open_folder(0);
        add_text("NULL");
        close_folder();
        add_word(32'h0001_0203);
        send_stream(stream_q.size());
        add_text("NULLDATA");
        add_word('0);
        send_stream(stream_q.size());
    endtask

    task automatic test_bad_name();
        logic [7:0] odd_chars [9] = '{8'h00, 8'h1F, 8'h21, 8'h2F, 8'h3A, 8'h40,
                                      8'h5B, 8'h61, 8'hFF};
        int k;
        stream_q.push_back(8'h40);
        add_text("ABC");
        stream_q.push_back(8'hFF);
        stream_q.push_back(8'h00);
        add_text("FORM");
        send_stream(stream_q.size());
        for (k = 0; k < 9; k++)
        begin
            add_text("AZ9 ");
            stream_q[k % 4] = odd_chars[k];
            send_stream(4);
        end
    endtask

    task automatic test_truncated_header();
        add_text("Q");
        send_stream(1);
        add_text("ABCD");
        add_word('0);
        send_stream(6);
        add_text("ABCDEFGH");
        send_stream(8);
        add_text("ABCDEFGH");
        add_word('0);
        send_stream(11);
        add_text("DATA");
        add_word(32'd5);
        add_random(2);
        send_stream(stream_q.size());
    endtask

    task automatic test_overlong_payload();
        add_text("BIG ");
        add_word(32'hFFFF_FFFF);
        add_random(3);
        send_stream(stream_q.size());
        add_text("FORM");
        add_word(32'hFFFF_FFF0);
        add_text("LEAF");
        add_word('0);
        send_stream(stream_q.size());
        add_text("FORM");
        add_word(32'd3);
        add_random(3);
        add_text("NEXT");
        add_word('0);
        send_stream(stream_q.size());
    endtask

    task automatic test_deep_nesting();
        wait_drained();
        repeat (STACK_DEPTH_DEF) open_folder(0);
        add_data(1'b0, 0);
        while (size_marks.size() > 0)
            close_folder();
        add_data(1'b0, 0);
        send_stream(stream_q.size());
    endtask

    task automatic test_stack_overflow();
        repeat (STACK_DEPTH_DEF + 1) open_folder($urandom_range(0, 2));
        add_data(1'b1, 1);
        while (size_marks.size() > 0)
            close_folder();
        send_stream(stream_q.size());
    endtask

    task automatic test_random_streams();
        int start;
        int pick;
        start = live_bytes;
        while (live_bytes - start < 400)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 8)
            begin
                add_random($urandom_range(1, 16));
                send_stream(stream_q.size());
            end
            else
            begin
                build_tree($urandom_range(1, 8));
                if (pick == 7)
                    send_stream($urandom_range(1, stream_q.size()));
                else
                begin
                    if (pick == 9)
                        stream_q[$urandom_range(0, stream_q.size() - 1)] = 8'($urandom);
                    send_stream(stream_q.size());
                end
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    task automatic test_steady_flow();
        calm = 1'b1;
        repeat (4)
        begin
            build_tree($urandom_range(3, 8));
            send_stream(stream_q.size());
        end
    endtask

    initial
    begin
        bytes_ch.valid <= 1'b0;
        bytes_ch.data_byte <= '0;
        bytes_ch.last_byte <= 1'b0;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_name_lengths();
        test_nested_folders();
        test_null_name();
        test_bad_name();
        test_truncated_header();
        test_overlong_payload();
        test_deep_nesting();
        test_stack_overflow();
        test_random_streams();
        test_steady_flow();
        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/iffchp_pkg.sv
sv/iffchp_ifs.sv
sv/iffchp_ram.sv
sv/iff_chunk_header_parser.sv
verif/iff_chunk_header_parser_test.sv
